### rtl/rmtt_pkg.sv
// Types, codes and helpers shared by the range translation table.
`default_nettype none
package rmtt_pkg;

  localparam logic [1:0] MODE_MAP   = 2'd0;
  localparam logic [1:0] MODE_UNMAP = 2'd1;
  localparam logic [1:0] MODE_FWD   = 2'd2;
  localparam logic [1:0] MODE_REV   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  localparam logic [31:0] WINDOW_RESET = 32'h1300_0000;
  localparam logic [1:0]  LANE_MASK    = 2'h3;

  localparam logic REG_WINDOW_BASE = 1'b0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] host_address;
    logic [31:0] emulated_address;
    logic [31:0] length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] emulated_result;
    logic [63:0] host_result;
    logic [63:0] region_host_base;
    logic [31:0] region_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] host_base;
    logic [31:0] mapped_base;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    logic load_new;
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

  // raise cand until its low lane bits equal the host's
  function automatic logic [31:0] align_to_host(input logic [31:0] cand,
                                                input logic [63:0] host);
    logic [1:0] delta;
    delta = (host[1:0] - cand[1:0]) & LANE_MASK;
    return cand + {30'b0, delta};
  endfunction

endpackage
`default_nettype wire

### rtl/rmtt_cell.sv
// One table slot: holds a range, compares it, shifts with its neighbors.
`default_nettype none
module rmtt_cell (
  input  wire logic              clk,
  input  wire rmtt_pkg::cell_ctl_t ctl,
  input  wire rmtt_pkg::in_item_t  op,
  input  wire logic [31:0]       prev_end,
  input  wire logic [31:0]       new_base,
  input  wire rmtt_pkg::entry_t    prev_entry,
  input  wire rmtt_pkg::entry_t    next_entry,
  output rmtt_pkg::entry_t         entry,
  output logic [31:0]            end_out,
  output logic [31:0]            cand,
  output logic                   fit,
  output logic                   host_hit,
  output logic                   emu_hit
);
  import rmtt_pkg::*;

  entry_t      entry_r, entry_nxt;
  logic [31:0] cand_r;
  logic        host_hit_r, emu_hit_r;
  logic [63:0] host_end;
  logic [31:0] emu_end;
  logic [31:0] need;

  assign host_end = entry_r.host_base + {32'b0, entry_r.length};
  assign emu_end  = entry_r.mapped_base + entry_r.length;
  assign need     = cand_r + op.length;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_new) begin
      entry_nxt.host_base   = op.host_address;
      entry_nxt.mapped_base = new_base;
      entry_nxt.length      = op.length;
    end else if (ctl.take_prev) begin
      entry_nxt = prev_entry;
    end else if (ctl.take_next) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp_en) begin
      cand_r     <= align_to_host(prev_end, op.host_address);
      host_hit_r <= (op.host_address >= entry_r.host_base) &&
                    (op.host_address < host_end);
      emu_hit_r  <= (op.emulated_address >= entry_r.mapped_base) &&
                    (op.emulated_address < emu_end);
    end
  end

  assign entry    = entry_r;
  assign end_out  = emu_end;
  assign cand     = cand_r;
  assign fit      = entry_r.mapped_base >= need;
  assign host_hit = host_hit_r;
  assign emu_hit  = emu_hit_r;

endmodule
`default_nettype wire

### rtl/range_map_translation_table_core.sv
// Top level of the range translation table: control, cell row and APB register.
//
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------
// input     | start / busy              | in_item  (in_item_t)
// result    | out_valid (one-cycle)     | out_item (out_item_t)
// config    | psel, penable, pwrite     | paddr, pwdata, prdata
//
// Each item passes three stages: compare in every cell, select and shift the
// row, then form the result. The result strobe rises in the same cycle that
// busy falls, after the output state; busy stays high from the accepting edge
// until then, so no new item is accepted before the last one is through. Reset
// empties the table. The result cannot be stalled; it shows for exactly one cycle.
`default_nettype none
module range_map_translation_table_core #(
  parameter int MAX_RANGES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rmtt_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output rmtt_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import rmtt_pkg::*;

  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam logic [MAX_RANGES-1:0] ONE_V = MAX_RANGES'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      window_base_r;
  in_item_t         op_r;
  entry_t           match_r;
  logic             found_r;
  logic [31:0]      cand_sel_r;
  logic [1:0]       status_r;
  out_item_t        out_item_r, out_item_nxt;
  logic             out_valid_r;

  entry_t          entries [MAX_RANGES];
  logic [31:0]     ends    [MAX_RANGES];
  logic [31:0]     cands   [MAX_RANGES];
  cell_ctl_t       ctls    [MAX_RANGES];
  logic [MAX_RANGES-1:0] fit_v, host_v, emu_v, active_v, tail_v;
  logic [MAX_RANGES-1:0] sel_v, first_v, ge_v, gt_v;
  logic            found;
  entry_t          match_sel;
  logic [31:0]     cand_sel;
  logic            do_insert, do_delete;
  logic            accept, cfg_wr;

  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_BASE) ? window_base_r : 32'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_RANGES; g++) begin : g_cell
      assign active_v[g] = count_r > CNT_W'(g);
      assign tail_v[g]   = count_r == CNT_W'(g);

      always_comb begin
        ctls[g].cmp_en    = state_r == S_CMP;
        ctls[g].load_new  = do_insert && first_v[g];
        ctls[g].take_prev = do_insert && gt_v[g];
        ctls[g].take_next = do_delete && ge_v[g];
      end

      rmtt_cell u_cell (
        .clk        (clk),
        .ctl        (ctls[g]),
        .op         (op_r),
        .prev_end   ((g == 0) ? window_base_r : ends[(g == 0) ? 0 : g - 1]),
        .new_base   (cand_sel),
        .prev_entry (entries[(g == 0) ? 0 : g - 1]),
        .next_entry (entries[(g == MAX_RANGES - 1) ? g : g + 1]),
        .entry      (entries[g]),
        .end_out    (ends[g]),
        .cand       (cands[g]),
        .fit        (fit_v[g]),
        .host_hit   (host_v[g]),
        .emu_hit    (emu_v[g])
      );
    end
  endgenerate

  always_comb begin
    case (op_r.mode)
      MODE_MAP: sel_v = (fit_v & active_v) | tail_v;
      MODE_FWD: sel_v = emu_v & active_v;
      default:  sel_v = host_v & active_v;
    endcase
  end

  assign first_v = sel_v & (~sel_v + ONE_V);
  assign ge_v    = ~(first_v - ONE_V);
  assign gt_v    = ge_v & ~first_v;
  assign found   = |sel_v;

  always_comb begin
    match_sel = '0;
    cand_sel  = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (first_v[i]) begin
        match_sel = entries[i];
        cand_sel  = cands[i];
      end
    end
  end

  assign do_insert = (state_r == S_SEL) && (op_r.mode == MODE_MAP) &&
                     (op_r.host_address != 64'b0) &&
                     (count_r < CNT_W'(MAX_RANGES));
  assign do_delete = (state_r == S_SEL) && (op_r.mode == MODE_UNMAP) &&
                     (op_r.host_address != 64'b0) && found;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      window_base_r <= WINDOW_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= state_r == S_OUT;
      if (cfg_wr && paddr[2] == REG_WINDOW_BASE) begin
        window_base_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_item;
    end
    if (state_r == S_SEL) begin
      match_r    <= match_sel;
      found_r    <= found;
      cand_sel_r <= cand_sel;
      case (op_r.mode)
        MODE_MAP: begin
          if (op_r.host_address == 64'b0) begin
            status_r <= ST_NULL;
          end else if (count_r >= CNT_W'(MAX_RANGES)) begin
            status_r <= ST_FULL;
          end else begin
            status_r <= ST_OK;
          end
        end
        MODE_UNMAP: begin
          if (op_r.host_address == 64'b0) begin
            status_r <= ST_NULL;
          end else begin
            status_r <= found ? ST_OK : ST_NOMATCH;
          end
        end
        default: status_r <= found ? ST_OK : ST_NOMATCH;
      endcase
    end
    if (state_r == S_OUT) begin
      out_item_r <= out_item_nxt;
    end
  end

  logic [31:0] fwd_off, fwd_left;
  logic [63:0] host_off;
  assign fwd_off  = op_r.emulated_address - match_r.mapped_base;
  assign fwd_left = match_r.length - fwd_off;
  assign host_off = op_r.host_address - match_r.host_base;

  always_comb begin
    out_item_nxt        = '0;
    out_item_nxt.status = status_r;
    case (op_r.mode)
      MODE_MAP: begin
        if (status_r == ST_OK) begin
          out_item_nxt.emulated_result = cand_sel_r;
        end
      end
      MODE_FWD: begin
        if (found_r) begin
          out_item_nxt.region_host_base = match_r.host_base;
          out_item_nxt.region_length    = match_r.length;
          if (op_r.length > fwd_left) begin
            out_item_nxt.status = ST_NOMATCH;
          end else begin
            out_item_nxt.host_result = match_r.host_base + {32'b0, fwd_off};
          end
        end
      end
      default: begin
        if (status_r == ST_OK) begin
          out_item_nxt.region_host_base = match_r.host_base;
          out_item_nxt.region_length    = match_r.length;
          out_item_nxt.emulated_result  = (op_r.mode == MODE_REV) ?
              match_r.mapped_base + host_off[31:0] : match_r.mapped_base;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the range translation table: command beats checked against a table predictor.
module tb_top;
  import rmtt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_OPS = 150;
  localparam logic [2:0] WINDOW_ADDR = {REG_WINDOW_BASE, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  range_map_translation_table_core #(.MAX_RANGES(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predicted table contents
  logic [63:0] tbl_host [TABLE_DEPTH];
  logic [31:0] tbl_emu  [TABLE_DEPTH];
  logic [31:0] tbl_len  [TABLE_DEPTH];
  int          tbl_count;
  logic [31:0] win_base;

  out_item_t pending[$];
  int        errors = 0;
  int        cycles = 0;
  bit        idle_on;
  int        mode_seen[4];
  int        status_seen[4];

  function automatic in_item_t mk_op(input logic [1:0] mode, input logic [63:0] host,
                                     input logic [31:0] emu, input logic [31:0] len);
    in_item_t op;
    op.mode = mode;
    op.host_address = host;
    op.emulated_address = emu;
    op.length = len;
    return op;
  endfunction

  function automatic logic [31:0] lane_align(input logic [31:0] cand, input logic [63:0] host);
    logic [1:0] delta;
    delta = host[1:0] - cand[1:0];
    return cand + {30'd0, delta};
  endfunction

  function automatic int host_slot(input logic [63:0] h);
    logic [63:0] lim;
    for (int i = 0; i < tbl_count; i++) begin
      lim = tbl_host[i] + {32'd0, tbl_len[i]};
      if (h >= tbl_host[i] && h < lim) return i;
    end
    return -1;
  endfunction

  function automatic int emu_slot(input logic [31:0] a);
    logic [31:0] lim;
    for (int i = 0; i < tbl_count; i++) begin
      lim = tbl_emu[i] + tbl_len[i];
      if (a >= tbl_emu[i] && a < lim) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t table_op(input in_item_t op);
    out_item_t   r;
    int          k;
    int          pos;
    logic [31:0] cand;
    logic [31:0] lim;
    logic [31:0] off;
    logic [63:0] hdiff;
    r = '0;
    case (op.mode)
      MODE_MAP: begin
        if (op.host_address == '0) begin
          r.status = ST_NULL;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cand = lane_align(win_base, op.host_address);
          pos = tbl_count;
          for (int i = 0; i < tbl_count; i++) begin
            lim = cand + op.length;
            if (tbl_emu[i] >= lim) begin
              pos = i;
              break;
            end
            cand = lane_align(tbl_emu[i] + tbl_len[i], op.host_address);
          end
          for (int i = tbl_count; i > pos; i--) begin
            tbl_host[i] = tbl_host[i-1];
            tbl_emu[i]  = tbl_emu[i-1];
            tbl_len[i]  = tbl_len[i-1];
          end
          tbl_host[pos] = op.host_address;
          tbl_emu[pos]  = cand;
          tbl_len[pos]  = op.length;
          tbl_count++;
          r.status = ST_OK;
          r.emulated_result = cand;
        end
      end
      MODE_UNMAP: begin
        if (op.host_address == '0) begin
          r.status = ST_NULL;
        end else begin
          k = host_slot(op.host_address);
          if (k < 0) begin
            r.status = ST_NOMATCH;
          end else begin
            r.emulated_result = tbl_emu[k];
            r.region_host_base = tbl_host[k];
            r.region_length = tbl_len[k];
            for (int i = k; i + 1 < tbl_count; i++) begin
              tbl_host[i] = tbl_host[i+1];
              tbl_emu[i]  = tbl_emu[i+1];
              tbl_len[i]  = tbl_len[i+1];
            end
            tbl_count--;
          end
        end
      end
      MODE_FWD: begin
        k = emu_slot(op.emulated_address);
        if (k < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          off = op.emulated_address - tbl_emu[k];
          lim = tbl_len[k] - off;
          r.region_host_base = tbl_host[k];
          r.region_length = tbl_len[k];
          if (op.length > lim) r.status = ST_NOMATCH;
          else r.host_result = tbl_host[k] + {32'd0, off};
        end
      end
      default: begin
        k = host_slot(op.host_address);
        if (k < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          hdiff = op.host_address - tbl_host[k];
          r.emulated_result = tbl_emu[k] + hdiff[31:0];
          r.region_host_base = tbl_host[k];
          r.region_length = tbl_len[k];
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] offset_in(input logic [31:0] len);
    return (len == '0) ? 32'h0 : 32'($urandom_range(0, len - 1));
  endfunction

  // mostly well-formed ops aimed at live entries, some raw noise
  function automatic in_item_t random_op();
    in_item_t    op;
    int          pick;
    int          k;
    logic [31:0] off;
    logic [31:0] room;
    op = mk_op(2'($urandom), {$urandom, $urandom}, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) return op;
    k = (tbl_count > 0) ? int'($urandom_range(0, tbl_count - 1)) : -1;
    if (pick < 35 || k < 0) begin
      op.mode = MODE_MAP;
      if (k >= 0 && $urandom_range(0, 3) == 0)
        op.host_address = tbl_host[k] + 64'($urandom_range(0, 255));
      if (op.host_address == '0) op.host_address = 64'h1;
      case ($urandom_range(0, 9))
        0:       op.length = $urandom | 32'h1;
        1, 2:    op.length = $urandom_range(1, 32'h10_0000);
        default: op.length = $urandom_range(1, 32'h1000);
      endcase
    end else if (pick < 60) begin
      op.mode = MODE_UNMAP;
      op.host_address = tbl_host[k] + {32'd0, offset_in(tbl_len[k])};
    end else if (pick < 82) begin
      op.mode = MODE_FWD;
      off = offset_in(tbl_len[k]);
      room = tbl_len[k] - off;
      op.emulated_address = tbl_emu[k] + off;
      case ($urandom_range(0, 2))
        0:       op.length = '0;
        1:       op.length = $urandom_range(0, room);
        default: op.length = room + 32'd1 + 32'($urandom_range(0, 15));
      endcase
    end else begin
      op.mode = MODE_REV;
      op.host_address = tbl_host[k] + {32'd0, offset_in(tbl_len[k])};
    end
    return op;
  endfunction

  // start stays high across back-to-back beats
  task automatic send_op(input in_item_t op);
    int        gap;
    out_item_t r;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy !== 1'b0);
    r = table_op(op);
    pending.push_back(r);
    mode_seen[op.mode]++;
    status_seen[r.status]++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_base = value;
  endtask

  // unmap every entry whose host range holds something
  task automatic unmap_all();
    int k;
    do begin
      k = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_len[i] != '0 && tbl_host[i] + {32'd0, tbl_len[i]} > tbl_host[i]) begin
          k = i;
          break;
        end
      end
      if (k >= 0) send_op(mk_op(MODE_UNMAP, tbl_host[k], '0, '0));
    end while (k >= 0);
  endtask

  task automatic test_null_and_empty();
    send_op(mk_op(MODE_MAP, '0, '0, 32'h100));
    send_op(mk_op(MODE_UNMAP, '0, '0, '0));
    send_op(mk_op(MODE_REV, '0, '0, '0));
    send_op(mk_op(MODE_FWD, '0, WINDOW_RESET, 32'h4));
    send_op(mk_op(MODE_UNMAP, 64'h1234, '0, '0));
  endtask

  task automatic test_map_and_lookup();
    send_op(mk_op(MODE_MAP, 64'h0000_0000_8000_1002, '0, 32'h1000));
    send_op(mk_op(MODE_MAP, 64'hFFFF_FFFF_FFFF_F001, '0, 32'h2000));
    send_op(mk_op(MODE_MAP, 64'h0000_0000_8000_1800, '0, 32'h100));
    send_op(mk_op(MODE_MAP, 64'h5555_AAAA_5555_AAA3, '0, '0));
    send_op(mk_op(MODE_MAP, 64'h0000_0001_0000_0000, '0, 32'hFFFF_FFFF));
    send_op(mk_op(MODE_FWD, '0, 32'h1300_0012, 32'h4));
    send_op(mk_op(MODE_FWD, '0, 32'h1300_0FF2, 32'h20));
    send_op(mk_op(MODE_FWD, '0, 32'h1300_1001, '0));
    send_op(mk_op(MODE_FWD, '0, 32'h1300_0002, 32'hFFFF_FFFF));
    send_op(mk_op(MODE_REV, 64'h0000_0000_8000_1850, '0, '0));
    send_op(mk_op(MODE_REV, 64'hFFFF_FFFF_FFFF_F800, '0, '0));
    send_op(mk_op(MODE_REV, 64'h0000_0001_7FFF_FFFF, '0, '0));
    send_op(mk_op(MODE_UNMAP, 64'h0000_0000_8000_1002, '0, '0));
    send_op(mk_op(MODE_UNMAP, 64'h0000_0000_8000_1002, '0, '0));
    send_op(mk_op(MODE_UNMAP, 64'h0000_0001_0000_0000, '0, '0));
    send_op(mk_op(MODE_UNMAP, 64'h0000_0000_8000_1800, '0, '0));
  endtask

  task automatic test_full_table();
    while (tbl_count < TABLE_DEPTH)
      send_op(mk_op(MODE_MAP, {32'd0, 32'($urandom_range(1, 32'h7FFF_FFFF))}, '0,
                    $urandom_range(1, 32'h400)));
    send_op(mk_op(MODE_MAP, 64'hDEAD_0000_0000_0001, '0, 32'h10));
    unmap_all();
  endtask

  task automatic test_random_traffic(input logic [31:0] window, input int n);
    write_window(window);
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) idle_on = $urandom_range(0, 1);
      send_op(random_op());
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        want = pending.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("emulated_result", want.emulated_result, out_item.emulated_result);
        check_field("host_result", want.host_result, out_item.host_result);
        check_field("region_host_base", want.region_host_base, out_item.region_host_base);
        check_field("region_length", want.region_length, out_item.region_length);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    tbl_count = 0;
    win_base = WINDOW_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_null_and_empty();
    test_map_and_lookup();
    test_full_table();
    test_random_traffic(32'h0000_0000, PHASE_OPS);
    test_random_traffic(32'hFFFF_FFFF, PHASE_OPS);
    test_random_traffic(32'hFFFF_F000, PHASE_OPS);
    test_random_traffic($urandom, PHASE_OPS);
    test_random_traffic(WINDOW_RESET, PHASE_OPS);
    wait_idle();

    $display("tb_top: %0d beats: map %0d, unmap %0d, forward %0d, reverse %0d",
             mode_seen[0] + mode_seen[1] + mode_seen[2] + mode_seen[3],
             mode_seen[MODE_MAP], mode_seen[MODE_UNMAP], mode_seen[MODE_FWD],
             mode_seen[MODE_REV]);
    $display("tb_top: status ok %0d, miss/overrun %0d, full %0d, null %0d over 5 windows",
             status_seen[ST_OK], status_seen[ST_NOMATCH], status_seen[ST_FULL],
             status_seen[ST_NULL]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
